// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/eth_csr_pkg.sv -----
// ----------------------------------------------------------------------------
// eth_csr_pkg
// Widths, CSR0 bit map, select codes and stage types of the CSR port.
// ----------------------------------------------------------------------------
package eth_csr_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;

    localparam int DATA_W     = 16;
    localparam int SIZE_W     = 3;
    localparam int ADDR_W     = 25;
    localparam int IADR_W     = 24;
    localparam int S_TDATA_W  = 48;   // size, address, write data, zero fill
    localparam int M_TDATA_W  = 24;   // read data, irq, zero fill

    // CSR0 bit positions
    localparam int ST_ERR  = 15;
    localparam int ST_BABL = 14;
    localparam int ST_CERR = 13;
    localparam int ST_MISS = 12;
    localparam int ST_MERR = 11;
    localparam int ST_RINT = 10;
    localparam int ST_TINT = 9;
    localparam int ST_IDON = 8;
    localparam int ST_INTR = 7;
    localparam int ST_INEA = 6;
    localparam int ST_TDMD = 3;
    localparam int ST_STOP = 2;
    localparam int ST_STRT = 1;
    localparam int ST_INIT = 0;

    localparam logic [DATA_W-1:0] CSR0_RESET  = 16'h0004;
    localparam logic [DATA_W-1:0] W1C_MASK    = 16'h7f00;
    localparam logic [DATA_W-1:0] LOAD_MASK   = 16'h0048;   // INEA, TDMD
    localparam logic [DATA_W-1:0] ERR_SRC     = 16'h7800;
    localparam logic [DATA_W-1:0] INTR_SRC    = 16'h5f00;

    // CSR select codes
    localparam logic [1:0] SEL_CSR0 = 2'd0;
    localparam logic [1:0] SEL_CSR1 = 2'd1;
    localparam logic [1:0] SEL_CSR2 = 2'd2;
    localparam logic [1:0] SEL_CSR3 = 2'd3;

    // register offsets (address bits 23..2)
    localparam logic [21:0] REG_RDP = 22'd0;
    localparam logic [21:0] REG_RAP = 22'd1;

    localparam logic [SIZE_W-1:0] SIZE_REG = 3'd2;

    typedef struct packed {
        logic              ok;
        logic              mem_rd;
        logic [DATA_W-1:0] rdata;
        logic              irq;
    } t_stage;

endpackage

// ----- hw/rtl/ethernet_controller_csr_port.sv -----
// ----------------------------------------------------------------------------
// ethernet_controller_csr_port
// Flow: an accepted request and its RAM read go to the request stage, then to the output register.
// Throughput: one request per cycle while the result channel is not stalled; buffer RAM has one port, read or write.
// Backpressure: a request stage and an output register hold two requests.
// Reset: synchronous, active low; CSR0 = STOP, other CSRs and irq cleared.
// Buffer RAM is not cleared; words read before being written are undefined.
// ----------------------------------------------------------------------------
module ethernet_controller_csr_port
    import eth_csr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [2:0] access_size, [27:3] address,
                                                // [43:28] write_data, [47:44] zero
    input  logic                 s_axis_tuser,  // [0] op (1 write, 0 read)
    // result channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [15:0] read_data, [16] irq_level,
                                                // [23:17] zero
    output logic                 m_axis_tuser   // [0] accepted
);

    localparam int WORDS    = BUFFER_BYTES / 2;
    localparam int MEM_AW   = $clog2(WORDS);
    // buffer offsets below twice the buffer size are in range
    localparam logic [25:0] BUF_LIMIT = 26'(2 * BUFFER_BYTES);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic              req_acc;
    logic              req_wr;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] req_addr;
    logic [DATA_W-1:0] req_wdata;
    logic [25:0]       buf_off;
    logic              aligned;
    logic              buf_ok;
    logic              reg_ok;
    logic              is_rdp;
    logic              is_rap;
    logic [MEM_AW-1:0] mem_idx;

    assign req_acc   = s_axis_tvalid && s_axis_tready;
    assign req_wr    = s_axis_tuser;
    assign req_size  = s_axis_tdata[2:0];
    assign req_addr  = s_axis_tdata[27:3];
    assign req_wdata = s_axis_tdata[43:28];

    assign aligned = (req_addr[1:0] == 2'b00);
    assign buf_off = {2'b00, req_addr[IADR_W-1:0]};
    assign buf_ok  = aligned && req_addr[ADDR_W-1] && (buf_off < BUF_LIMIT);
    // word index is the byte offset divided by four
    assign mem_idx = buf_off[MEM_AW+1:2];
    assign reg_ok  = aligned && !req_addr[ADDR_W-1] && (req_size == SIZE_REG);
    assign is_rdp  = (req_addr[23:2] == REG_RDP);
    assign is_rap  = (req_addr[23:2] == REG_RAP);

    // ------------------------------------------------------------------
    // CSR state
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_status;
    logic [IADR_W-1:0] r_iadr;
    logic [1:0]        r_sel;
    logic              r_bswp;
    logic              r_acon;
    logic              r_bcon;
    logic              r_irq;

    logic              stopped;
    logic              csr0_wr;
    logic              csrx_wr;
    logic              rap_wr;
    logic              req_ok;
    logic [DATA_W-1:0] n_status;
    logic              n_irq;
    logic [DATA_W-1:0] csr_rd;
    logic [DATA_W-1:0] reg_rd;

    assign stopped = r_status[ST_STOP];
    // CSR1..3 only take writes while stopped; reads are always accepted but return zero unless stopped
    assign csr0_wr = req_acc && reg_ok && is_rdp && req_wr && (r_sel == SEL_CSR0);
    assign csrx_wr = req_acc && reg_ok && is_rdp && req_wr && (r_sel != SEL_CSR0)
                     && stopped;
    assign rap_wr  = req_acc && reg_ok && is_rap && req_wr;
    assign req_ok  = buf_ok || (reg_ok && is_rap) ||
                     (reg_ok && is_rdp && (!req_wr || (r_sel == SEL_CSR0) || stopped));

    // CSR0 write: clear the write-one bits, load INEA, set TDMD when written, then apply
    // the commands (STOP over STRT over INIT) and refresh ERR and INTR.
    always_comb begin
        n_status = r_status & ~(req_wdata & W1C_MASK);
        n_status[ST_INEA] = 1'b0;
        n_status = n_status | (req_wdata & LOAD_MASK);
        if (req_wdata[ST_STOP]) begin
            n_status = CSR0_RESET;
        end else if (req_wdata[ST_STRT]) begin
            n_status[ST_STOP] = 1'b0;
            n_status[ST_STRT] = 1'b1;
        end else if (req_wdata[ST_INIT]) begin
            n_status[ST_STOP] = 1'b0;
            n_status[ST_INIT] = 1'b1;
            n_status[ST_IDON] = 1'b1;
        end
        n_status[ST_ERR]  = |(n_status & ERR_SRC);
        n_status[ST_INTR] = |(n_status & INTR_SRC);
        n_irq = csr0_wr ? (n_status[ST_INTR] && n_status[ST_INEA]) : r_irq;
    end

    always_comb begin
        case (r_sel)
            SEL_CSR0: csr_rd = r_status;
            SEL_CSR1: csr_rd = stopped ? r_iadr[15:0] : '0;
            SEL_CSR2: csr_rd = stopped ? {8'h00, r_iadr[23:16]} : '0;
            default:  csr_rd = stopped ? {12'h000, r_bswp, 1'b0, r_acon, r_bcon} : '0;
        endcase
        reg_rd = is_rap ? {14'h0000, r_sel} : csr_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= CSR0_RESET;
            r_iadr   <= '0;
            r_sel    <= SEL_CSR0;
            r_bswp   <= 1'b0;
            r_acon   <= 1'b0;
            r_bcon   <= 1'b0;
            r_irq    <= 1'b0;
        end else begin
            if (csr0_wr) begin
                r_status <= n_status;
            end
            r_irq <= n_irq;
            if (rap_wr) begin
                r_sel <= req_wdata[1:0];
            end
            if (csrx_wr) begin
                case (r_sel)
                    SEL_CSR1: r_iadr[15:0]  <= req_wdata & 16'hfffe;
                    SEL_CSR2: r_iadr[23:16] <= req_wdata[7:0];
                    default: begin
                        r_bswp <= req_wdata[3];
                        r_acon <= req_wdata[1];
                        r_bcon <= req_wdata[0];
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Buffer RAM: one port, write or read per request, read data registered
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_mem_q;
    logic              mem_we;
    logic              mem_re;

    assign mem_we = req_acc && buf_ok && req_wr;
    assign mem_re = req_acc && buf_ok && !req_wr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_idx] <= req_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_idx];
        end
    end

    // ------------------------------------------------------------------
    // Request stage and output register
    // ------------------------------------------------------------------
    logic   r_s1_valid;
    t_stage r_s1;
    t_stage n_s1;
    logic   r_out_valid;
    t_stage r_out;
    logic   s1_adv;

    // advance the request stage whenever the output register is free or drains
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;

    always_comb begin
        n_s1.ok     = req_ok;
        n_s1.mem_rd = buf_ok && !req_wr;
        n_s1.rdata  = (req_ok && !req_wr) ? reg_rd : '0;
        n_s1.irq    = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.ok     <= r_s1.ok;
            r_out.mem_rd <= r_s1.mem_rd;
            r_out.rdata  <= r_s1.mem_rd ? r_mem_q : r_s1.rdata;
            r_out.irq    <= r_s1.irq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.ok;
    assign m_axis_tdata  = {7'h00, r_out.irq, r_out.rdata};

endmodule

// ----- hw/rtl/eth_csr_chk.sv -----
// ----------------------------------------------------------------------------
// eth_csr_chk
// Port-level checks on the CSR port, bound into ethernet_controller_csr_port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eth_csr_chk
    import eth_csr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // hold a stalled result unchanged
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // a refused request returns no data
    `ASSERT_CLK_RST(a_refused_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0000, "refused request returned data")

    // with no result pending, new requests are always taken
    `ASSERT_CLK_RST(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "request stalled with empty output")

    // fill bits of the result stay zero
    `ASSERT_CLK_RST(a_fill_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[23:17] == 7'h00, "result fill bits not zero")

endmodule

bind ethernet_controller_csr_port eth_csr_chk u_eth_csr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
